// File: rtl/core/assert_macros.svh
// Assertion macros shared by the stepper core modules.
// Each macro expects aclk and aresetn in the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error(msg);

// Check that a condition holds in the cycle after a trigger.
`define ASSERT_NEXT(label, trig, prop, msg) \
    `ASSERT_CLK(label, (trig) |=> (prop), msg)

`endif

// File: rtl/core/mhs_pkg.sv
// Shared types, constants and coil table of the half-step stepper core.
// No dependencies.
package mhs_pkg;

    localparam int DEF_NUM_GROUPS       = 7;
    localparam int DEF_NUM_PETALS       = 7;
    localparam int DEF_MOTORS_PER_PETAL = 8;

    localparam int MODE_W   = 2;
    localparam int IDX_W    = 9;
    localparam int PERIOD_W = 10;
    localparam int PHASE_W  = 3;
    localparam int CNT_W    = 11;
    localparam int PLANE_W  = 7;
    localparam int NUM_PLANES = 4;
    localparam int SLOT_W   = 6;

    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 40;

    localparam logic [PERIOD_W-1:0] RESET_PERIOD = PERIOD_W'(1000);
    localparam logic [PHASE_W-1:0]  RESET_PHASE  = PHASE_W'(1);

    localparam logic [NUM_PLANES-1:0] COIL_PATTERN [8] = '{
        4'h2, 4'hA, 4'h8, 4'h9, 4'h1, 4'h5, 4'h4, 4'h6
    };

    typedef enum logic [MODE_W-1:0] {
        MODE_TICK   = 2'd0,
        MODE_FADE   = 2'd1,
        MODE_SET    = 2'd2,
        MODE_RELOAD = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PRIME,
        ST_RUN
    } ctrl_state_t;

    typedef struct packed {
        logic                dir;
        logic [CNT_W-1:0]    countdown;
        logic [PERIOD_W-1:0] target;
        logic [PERIOD_W-1:0] period;
        logic [PHASE_W-1:0]  phase;
    } chan_t;

    localparam chan_t RESET_CHAN = '{
        dir:       1'b0,
        countdown: '0,
        target:    '0,
        period:    RESET_PERIOD,
        phase:     RESET_PHASE
    };

    typedef struct packed {
        logic take;
        logic clear;
        logic rd_en;
        logic wr_en;
        logic out_load;
    } dp_cmd_t;

    typedef struct packed {
        mode_t mode;
        logic  set_ok;
        logic  out_free;
    } dp_status_t;

endpackage

// File: rtl/core/mhs_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mhs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/core/mhs_ctrl.sv
// Sequencer of the stepper core: clearing pass, item intake and slot sweep.
// Depends on mhs_pkg and assert_macros.svh.
`include "assert_macros.svh"
module mhs_ctrl #(
    parameter int NUM_PETALS       = mhs_pkg::DEF_NUM_PETALS,
    parameter int MOTORS_PER_PETAL = mhs_pkg::DEF_MOTORS_PER_PETAL,
    localparam int SLOTS = NUM_PETALS * MOTORS_PER_PETAL,
    localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  mhs_pkg::dp_status_t stat,
    input  logic [AW-1:0]       set_slot,
    output mhs_pkg::dp_cmd_t    cmd,
    output logic [AW-1:0]       rd_addr,
    output logic [AW-1:0]       wr_addr
);
    import mhs_pkg::*;

    localparam logic [AW-1:0] LAST_SLOT = AW'(SLOTS - 1);

    ctrl_state_t   state_reg, state_next;
    logic [AW-1:0] addr_reg, addr_next;
    logic          go;
    logic          sweep_end;

    assign go        = (stat.mode != MODE_TICK) || stat.out_free;
    assign sweep_end = (stat.mode == MODE_SET) || (addr_reg == LAST_SLOT);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            addr_reg  <= '0;
        end else begin
            state_reg <= state_next;
            addr_reg  <= addr_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                if (addr_reg == LAST_SLOT) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (s_tvalid) state_next = ST_PRIME;
            end
            ST_PRIME: begin
                if (stat.mode == MODE_SET && !stat.set_ok) state_next = ST_IDLE;
                else state_next = ST_RUN;
            end
            ST_RUN: begin
                if (go && sweep_end) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        addr_next = addr_reg;
        unique case (state_reg)
            ST_CLEAR: addr_next = (addr_reg == LAST_SLOT) ? '0 : addr_reg + AW'(1);
            ST_IDLE:  addr_next = '0;
            ST_PRIME: addr_next = (stat.mode == MODE_SET) ? set_slot : '0;
            ST_RUN: begin
                if (go && !sweep_end) addr_next = addr_reg + AW'(1);
            end
            default: addr_next = '0;
        endcase
    end

    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        rd_addr  = addr_reg;
        wr_addr  = addr_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                cmd.clear = 1'b1;
                cmd.wr_en = 1'b1;
            end
            ST_IDLE: begin
                s_tready = 1'b1;
                cmd.take = s_tvalid;
            end
            ST_PRIME: begin
                rd_addr   = (stat.mode == MODE_SET) ? set_slot : '0;
                cmd.rd_en = (stat.mode != MODE_SET) || stat.set_ok;
            end
            ST_RUN: begin
                if (go) begin
                    cmd.wr_en    = 1'b1;
                    cmd.out_load = (stat.mode == MODE_TICK);
                    if (!sweep_end) begin
                        cmd.rd_en = 1'b1;
                        rd_addr   = addr_reg + AW'(1);
                    end
                end
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

    `ASSERT_CLK(a_rw_apart, cmd.rd_en && cmd.wr_en |-> rd_addr != wr_addr,
        "read and write hit the same slot")
    `ASSERT_CLK(a_load_room, cmd.out_load |-> stat.out_free,
        "result loaded while output register is blocked")
    `ASSERT_NEXT(a_take_once, cmd.take, !cmd.take && !s_tready,
        "intake stayed open after a beat was taken")

endmodule

// File: rtl/core/mhs_datapath.sv
// Channel banks, per-channel update logic, item register and result register.
// Depends on mhs_pkg, mhs_ram and assert_macros.svh.
`include "assert_macros.svh"
module mhs_datapath #(
    parameter int NUM_GROUPS       = mhs_pkg::DEF_NUM_GROUPS,
    parameter int NUM_PETALS       = mhs_pkg::DEF_NUM_PETALS,
    parameter int MOTORS_PER_PETAL = mhs_pkg::DEF_MOTORS_PER_PETAL,
    localparam int SLOTS = NUM_PETALS * MOTORS_PER_PETAL,
    localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic [mhs_pkg::S_TDATA_W-1:0]      s_tdata,
    input  mhs_pkg::dp_cmd_t                   cmd,
    input  logic [AW-1:0]                      rd_addr,
    input  logic [AW-1:0]                      wr_addr,
    output mhs_pkg::dp_status_t                stat,
    output logic [AW-1:0]                      set_slot,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [mhs_pkg::M_TDATA_W-1:0]      m_tdata,
    output logic                               m_tlast
);
    import mhs_pkg::*;

    localparam int CHANNELS = NUM_GROUPS * SLOTS;
    localparam int GW = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;
    localparam int XW = ($clog2(CHANNELS + 1) > IDX_W) ? $clog2(CHANNELS + 1) : IDX_W;
    localparam int LIVE_GROUPS = (NUM_GROUPS < PLANE_W) ? NUM_GROUPS : PLANE_W;
    localparam int CHAN_W = $bits(chan_t);
    localparam logic [AW-1:0] LAST_SLOT = AW'(SLOTS - 1);

    // item register
    mode_t               mode_reg;
    logic                set_ok_reg;
    logic [GW-1:0]       set_grp_reg;
    logic [AW-1:0]       set_slot_reg;
    logic [PERIOD_W-1:0] target_reg;
    logic                back_reg;
    logic                force_reg;

    logic [XW-1:0] idx_x;
    logic [GW-1:0] grp_dec;
    logic [AW-1:0] slot_dec;
    logic          ok_dec;

    always_comb begin
        idx_x   = XW'(s_tdata[10:2]);
        grp_dec = '0;
        for (int k = 1; k < NUM_GROUPS; k++) begin
            if (idx_x >= XW'(k * SLOTS)) grp_dec = GW'(k);
        end
        slot_dec = AW'(idx_x - XW'(grp_dec * SLOTS));
        ok_dec   = idx_x < XW'(CHANNELS);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= MODE_TICK;
            set_ok_reg <= 1'b0;
        end else if (cmd.take) begin
            mode_reg   <= mode_t'(s_tdata[1:0]);
            set_ok_reg <= ok_dec;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.take) begin
            set_grp_reg  <= grp_dec;
            set_slot_reg <= slot_dec;
            target_reg   <= s_tdata[20:11];
            back_reg     <= s_tdata[21];
            force_reg    <= s_tdata[22];
        end
    end

    // channel banks, one per group
    chan_t              rd_data [NUM_GROUPS];
    chan_t              upd     [NUM_GROUPS];
    chan_t              wr_data [NUM_GROUPS];
    logic [NUM_GROUPS-1:0] wr_en;

    for (genvar g = 0; g < NUM_GROUPS; g++) begin : g_bank
        logic [CHAN_W-1:0] bank_rd;

        assign rd_data[g] = chan_t'(bank_rd);
        assign wr_data[g] = cmd.clear ? RESET_CHAN : upd[g];
        assign wr_en[g]   = cmd.wr_en && (cmd.clear || mode_reg != MODE_SET ||
                                          set_grp_reg == GW'(g));

        mhs_ram #(
            .WIDTH (CHAN_W),
            .DEPTH (SLOTS)
        ) u_bank (
            .aclk    (aclk),
            .wr_en   (wr_en[g]),
            .wr_addr (wr_addr),
            .wr_data (wr_data[g]),
            .rd_en   (cmd.rd_en),
            .rd_addr (rd_addr),
            .rd_data (bank_rd)
        );
    end

    always_comb begin
        for (int g = 0; g < NUM_GROUPS; g++) begin
            upd[g] = rd_data[g];
            unique case (mode_reg)
                MODE_TICK: begin
                    if (rd_data[g].countdown == '0) begin
                        upd[g].countdown = CNT_W'(rd_data[g].period);
                        upd[g].phase = rd_data[g].dir ? rd_data[g].phase - PHASE_W'(1)
                                                      : rd_data[g].phase + PHASE_W'(1);
                    end
                    if (!upd[g].countdown[CNT_W-1]) begin
                        upd[g].countdown = upd[g].countdown - CNT_W'(1);
                    end
                end
                MODE_FADE: begin
                    if (rd_data[g].target < rd_data[g].period) begin
                        upd[g].period = rd_data[g].period - PERIOD_W'(1);
                    end else if (rd_data[g].target > rd_data[g].period) begin
                        upd[g].period = rd_data[g].period + PERIOD_W'(1);
                    end
                    upd[g].countdown = CNT_W'(upd[g].period);
                end
                MODE_SET: begin
                    upd[g].target = target_reg;
                    upd[g].dir    = back_reg;
                    if (force_reg) upd[g].period = target_reg;
                end
                MODE_RELOAD: begin
                    upd[g].countdown = CNT_W'(rd_data[g].period);
                end
                default: begin
                    upd[g] = rd_data[g];
                end
            endcase
        end
    end

    // result register
    logic [NUM_PLANES-1:0][PLANE_W-1:0] plane;
    logic [NUM_PLANES-1:0][PLANE_W-1:0] plane_reg;
    logic [SLOT_W-1:0]                  slot_reg;
    logic                               out_last_reg;
    logic                               out_valid_reg, out_valid_next;

    always_comb begin
        plane = '0;
        for (int g = 0; g < LIVE_GROUPS; g++) begin
            for (int b = 0; b < NUM_PLANES; b++) begin
                plane[b][g] = COIL_PATTERN[upd[g].phase][b];
            end
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load) out_valid_next = 1'b1;
        else if (m_tready) out_valid_next = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            plane_reg    <= plane;
            slot_reg     <= SLOT_W'(wr_addr);
            out_last_reg <= (wr_addr == LAST_SLOT);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = M_TDATA_W'({slot_reg, plane_reg[3], plane_reg[2],
                                  plane_reg[1], plane_reg[0]});

    assign stat.mode     = mode_reg;
    assign stat.set_ok   = set_ok_reg;
    assign stat.out_free = !out_valid_reg || m_tready;
    assign set_slot      = set_slot_reg;

    `ASSERT_NEXT(a_load_shows, cmd.out_load, m_tvalid,
        "loaded result not presented")
    `ASSERT_CLK(a_set_slot_range, set_ok_reg |-> set_slot_reg <= LAST_SLOT,
        "decoded slot beyond the bank depth")
    `ASSERT_CLK(a_last_slot, m_tvalid && m_tlast |-> slot_reg == SLOT_W'(SLOTS - 1),
        "strobe beat not on the final slot")

endmodule

// File: rtl/core/multichannel_halfstep_stepper.sv
// Half-step sequencer for NUM_GROUPS * NUM_PETALS * MOTORS_PER_PETAL stepper channels,
// kept in one channel memory per group (NUM_PETALS * MOTORS_PER_PETAL slots each).
// After reset a clearing pass of one slot per cycle runs with s_tready low. A tick beat
// sweeps one slot per cycle while m_tready stays high, a rate set by the single read and
// write port of each group memory; it emits one result beat per slot, tlast on the last.
// Fade and reload beats sweep the same way without results; a set beat writes its one
// channel, or nothing when its channel index is out of range. Depends on mhs_pkg,
// mhs_ctrl and mhs_datapath.
module multichannel_halfstep_stepper #(
    parameter int NUM_GROUPS       = mhs_pkg::DEF_NUM_GROUPS,
    parameter int NUM_PETALS       = mhs_pkg::DEF_NUM_PETALS,
    parameter int MOTORS_PER_PETAL = mhs_pkg::DEF_MOTORS_PER_PETAL
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // mode[1:0], channel_index[10:2], target_period[20:11],
    // step_backward[21], force_period[22]
    input  logic [mhs_pkg::S_TDATA_W-1:0] s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // plane_zero[6:0], plane_one[13:7], plane_two[20:14],
    // plane_three[27:21], slot_number[33:28]
    output logic [mhs_pkg::M_TDATA_W-1:0] m_tdata,
    output logic                          m_tlast
);
    import mhs_pkg::*;

    localparam int SLOTS = NUM_PETALS * MOTORS_PER_PETAL;
    localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    dp_cmd_t       cmd;
    dp_status_t    stat;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] set_slot;

    mhs_ctrl #(
        .NUM_PETALS       (NUM_PETALS),
        .MOTORS_PER_PETAL (MOTORS_PER_PETAL)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .set_slot (set_slot),
        .cmd      (cmd),
        .rd_addr  (rd_addr),
        .wr_addr  (wr_addr)
    );

    mhs_datapath #(
        .NUM_GROUPS       (NUM_GROUPS),
        .NUM_PETALS       (NUM_PETALS),
        .MOTORS_PER_PETAL (MOTORS_PER_PETAL)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .cmd      (cmd),
        .rd_addr  (rd_addr),
        .wr_addr  (wr_addr),
        .stat     (stat),
        .set_slot (set_slot),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule
